@@ design/rtcca_pkg.sv @@
// Shared types, constants and calendar helper functions of the real-time clock.
package rtcca_pkg;

  localparam logic [11:0] YEAR_FIRST = 12'd1900;
  localparam logic [11:0] YEAR_LAST  = 12'd4095;

  // Multiplier and shift for an exact y / 100 over the whole 12-bit year range.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SET_TIME    = 3'd1,
    OP_SET_DATE    = 3'd2,
    OP_SET_ALARM   = 3'd3,
    OP_CLEAR_ALARM = 3'd4
  } opcode_e;

  // Month lengths (non-leap) and weekday offsets, indexed by month minus one.
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
  };
  localparam logic [2:0] MONTH_OFFSET [16] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1,
    3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [11:0] set_year;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_min;
    logic        armed;
    logic        active;
  } rtc_state_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] weekday;
  } date_chk_t;

  // Quotient of a year by 100 by reciprocal multiplication.
  function automatic logic [5:0] div100(logic [11:0] y);
    logic [24:0] prod;
    prod = 25'(y) * 25'(DIV100_MUL);
    return prod[DIV100_SHIFT +: 6];
  endfunction

  // Gregorian leap-year rule.
  function automatic logic is_leap(logic [11:0] y);
    logic [5:0]  q;
    logic [11:0] qx;
    logic        by100;
    logic        by400;
    q     = div100(y);
    qx    = 12'(q) * 12'd100;
    by100 = (qx == y);
    by400 = by100 && (q[1:0] == 2'b00);
    return ((y[1:0] == 2'b00) && !by100) || by400;
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] mo, logic [11:0] y);
    logic [3:0] idx;
    logic [4:0] n;
    idx = mo - 4'd1;
    n   = MONTH_LEN[idx];
    if (idx == 4'd1 && is_leap(y)) begin
      n = 5'd29;
    end
    return n;
  endfunction

endpackage

@@ design/rtcca_if.sv @@
// Command and status channel interfaces of the real-time clock.
interface rtcca_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [4:0]  set_hour;
  logic [5:0]  set_minute;
  logic [5:0]  set_second;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [11:0] set_year;

  modport source (output valid, opcode, set_hour, set_minute, set_second, set_day,
                  set_month, set_year, input ready);
  modport sink (input valid, opcode, set_hour, set_minute, set_second, set_day,
                set_month, set_year, output ready);
endinterface

interface rtcca_stat_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [11:0] cur_year;
  logic [2:0]  cur_weekday;
  logic        alarm_hit;
  logic        alarm_enabled;
  logic [4:0]  alarm_hour_out;
  logic [5:0]  alarm_minute_out;
  logic        accepted;

  modport source (output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
                  cur_year, cur_weekday, alarm_hit, alarm_enabled, alarm_hour_out,
                  alarm_minute_out, accepted, input ready);
  modport sink (input valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
                cur_year, cur_weekday, alarm_hit, alarm_enabled, alarm_hour_out,
                alarm_minute_out, accepted, output ready);
endinterface

@@ design/rtcca_date_check.sv @@
// Set-date validation and weekday calculation from day, month and year.
module rtcca_date_check import rtcca_pkg::*; (
  input  logic [4:0]  set_day_i,
  input  logic [3:0]  set_month_i,
  input  logic [11:0] set_year_i,
  output date_chk_t   chk_o
);

  logic [11:0] adj_year;
  logic [5:0]  q100;
  logic [12:0] wd_sum;
  logic [14:0] wd_pad;
  logic [5:0]  fold1;
  logic [3:0]  fold2;

  // January and February count as months of the previous year.
  assign adj_year = (set_month_i < 4'd3 && set_year_i != 12'd0) ?
                    set_year_i - 12'd1 : set_year_i;
  assign q100     = div100(adj_year);

  assign wd_sum = 13'(adj_year) + 13'(adj_year >> 2) - 13'(q100) + 13'(q100 >> 2)
                + 13'(MONTH_OFFSET[set_month_i - 4'd1]) + 13'(set_day_i);

  // Modulo 7 by summing octal digits, since 8 leaves a remainder of 1.
  assign wd_pad = {2'b00, wd_sum};
  assign fold1  = 6'(wd_pad[2:0]) + 6'(wd_pad[5:3]) + 6'(wd_pad[8:6])
                + 6'(wd_pad[11:9]) + 6'(wd_pad[14:12]);
  assign fold2  = 4'(fold1[2:0]) + 4'(fold1[5:3]);

  assign chk_o.weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  assign chk_o.valid   = (set_month_i >= 4'd1) && (set_month_i <= 4'd12)
                      && (set_year_i >= YEAR_FIRST) && (set_year_i <= YEAR_LAST)
                      && (set_day_i >= 5'd1)
                      && (set_day_i <= days_in(set_month_i, set_year_i));

endmodule

@@ design/rtc_calendar_alarm.sv @@
// Top level of the 24-hour real-time clock and calendar with alarm.
//
//  Channel   Direction  Handshake     Payload
//  cmd_i     in         valid/ready   opcode and set fields for time, date, alarm
//  stat_o    out        valid/ready   current time, date, weekday, alarm status, accepted
//
// Each command transaction is held in an input register; the next-state logic
// then updates the clock state and the status register together. One
// transaction per cycle is sustained while stat_o.ready is high; the status
// reaches stat_o through the input register and then the status register.
// The reset leaves the clock at 00:00:00 on Monday 1 January of the first
// year, with the alarm disarmed. While the status is stalled one further
// command waits in the input register, after which cmd_i.ready drops.
module rtc_calendar_alarm import rtcca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtcca_cmd_if.sink    cmd_i,
  rtcca_stat_if.source stat_o
);

  logic       s1_valid_q;
  cmd_t       s1_cmd_q;
  logic       out_valid_q;
  logic       accepted_q;
  logic       accepted_d;
  logic       advance;
  rtc_state_t state_q;
  rtc_state_t state_d;
  rtc_state_t tick_state;
  date_chk_t  date_chk;

  logic sec_wrap;
  logic min_wrap;
  logic hour_wrap;
  logic midnight;
  logic month_end;

  // The command moves on whenever the status register is empty or being read.
  assign advance     = s1_valid_q && (!out_valid_q || stat_o.ready);
  assign cmd_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (stat_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      s1_cmd_q.opcode     <= cmd_i.opcode;
      s1_cmd_q.set_hour   <= cmd_i.set_hour;
      s1_cmd_q.set_minute <= cmd_i.set_minute;
      s1_cmd_q.set_second <= cmd_i.set_second;
      s1_cmd_q.set_day    <= cmd_i.set_day;
      s1_cmd_q.set_month  <= cmd_i.set_month;
      s1_cmd_q.set_year   <= cmd_i.set_year;
    end
  end

  // Validation and weekday of the date carried by a set-date command.
  rtcca_date_check u_date_check (
    .set_day_i   (s1_cmd_q.set_day),
    .set_month_i (s1_cmd_q.set_month),
    .set_year_i  (s1_cmd_q.set_year),
    .chk_o       (date_chk)
  );

  // Next state for a tick: carries from seconds up to the year.
  assign sec_wrap  = (state_q.sec == 6'd59);
  assign min_wrap  = (state_q.min == 6'd59);
  assign hour_wrap = (state_q.hour == 5'd23);
  assign midnight  = sec_wrap && min_wrap && hour_wrap;
  assign month_end = (state_q.day >= days_in(state_q.month, state_q.year));

  always_comb begin
    tick_state     = state_q;
    tick_state.sec = sec_wrap ? 6'd0 : state_q.sec + 6'd1;
    if (sec_wrap) begin
      tick_state.min = min_wrap ? 6'd0 : state_q.min + 6'd1;
      if (min_wrap) begin
        tick_state.hour = hour_wrap ? 5'd0 : state_q.hour + 5'd1;
      end
    end
    // The alarm fires only on the tick that lands exactly on hh:mm:00.
    tick_state.active = state_q.armed && sec_wrap
                     && (tick_state.hour == state_q.alarm_hour)
                     && (tick_state.min == state_q.alarm_min);
    if (midnight) begin
      tick_state.weekday = (state_q.weekday >= 3'd6) ? 3'd0 : state_q.weekday + 3'd1;
      if (month_end) begin
        tick_state.day = 5'd1;
        if (state_q.month >= 4'd12) begin
          tick_state.month = 4'd1;
          tick_state.year  = (state_q.year >= YEAR_LAST) ? YEAR_FIRST : state_q.year + 12'd1;
        end else begin
          tick_state.month = state_q.month + 4'd1;
        end
      end else begin
        tick_state.day = state_q.day + 5'd1;
      end
    end
  end

  // Command decode. Invalid set commands and unknown opcodes leave the state alone.
  always_comb begin
    state_d    = state_q;
    accepted_d = 1'b0;
    unique case (s1_cmd_q.opcode)
      OP_TICK: begin
        state_d    = tick_state;
        accepted_d = 1'b1;
      end
      OP_SET_TIME: begin
        if (s1_cmd_q.set_hour <= 5'd23 && s1_cmd_q.set_minute <= 6'd59
            && s1_cmd_q.set_second <= 6'd59) begin
          state_d.hour = s1_cmd_q.set_hour;
          state_d.min  = s1_cmd_q.set_minute;
          state_d.sec  = s1_cmd_q.set_second;
          accepted_d   = 1'b1;
        end
      end
      OP_SET_DATE: begin
        if (date_chk.valid) begin
          state_d.year    = s1_cmd_q.set_year;
          state_d.month   = s1_cmd_q.set_month;
          state_d.day     = s1_cmd_q.set_day;
          state_d.weekday = date_chk.weekday;
          accepted_d      = 1'b1;
        end
      end
      OP_SET_ALARM: begin
        if (s1_cmd_q.set_hour <= 5'd23 && s1_cmd_q.set_minute <= 6'd59) begin
          state_d.alarm_hour = s1_cmd_q.set_hour;
          state_d.alarm_min  = s1_cmd_q.set_minute;
          state_d.armed      = 1'b1;
          accepted_d         = 1'b1;
        end
      end
      OP_CLEAR_ALARM: begin
        state_d.armed  = 1'b0;
        state_d.active = 1'b0;
        accepted_d     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The clock state doubles as the status register: it only changes when a
  // new status transaction is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.sec        <= 6'd0;
      state_q.min        <= 6'd0;
      state_q.hour       <= 5'd0;
      state_q.day        <= 5'd1;
      state_q.month      <= 4'd1;
      state_q.year       <= YEAR_FIRST;
      state_q.weekday    <= 3'd1;
      state_q.alarm_hour <= 5'd0;
      state_q.alarm_min  <= 6'd0;
      state_q.armed      <= 1'b0;
      state_q.active     <= 1'b0;
      accepted_q         <= 1'b0;
    end else if (advance) begin
      state_q    <= state_d;
      accepted_q <= accepted_d;
    end
  end

  assign stat_o.valid            = out_valid_q;
  assign stat_o.cur_second       = state_q.sec;
  assign stat_o.cur_minute       = state_q.min;
  assign stat_o.cur_hour         = state_q.hour;
  assign stat_o.cur_day          = state_q.day;
  assign stat_o.cur_month        = state_q.month;
  assign stat_o.cur_year         = state_q.year;
  assign stat_o.cur_weekday      = state_q.weekday;
  assign stat_o.alarm_hit        = state_q.active;
  assign stat_o.alarm_enabled    = state_q.armed;
  assign stat_o.alarm_hour_out   = state_q.alarm_hour;
  assign stat_o.alarm_minute_out = state_q.alarm_min;
  assign stat_o.accepted         = accepted_q;

  // A tick that does not wrap the seconds adds exactly one second.
  a_tick_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_cmd_q.opcode == OP_TICK) && !sec_wrap
    |=> state_q.sec == $past(state_q.sec) + 6'd1)
    else $error("tick did not advance the seconds by one");

  // The alarm can only rise while armed and on a whole minute.
  a_alarm_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.active) |-> state_q.armed && (state_q.sec == 6'd0))
    else $error("alarm raised off the minute or while disarmed");

  // A rejected command leaves the year, day, hour and seconds untouched.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !accepted_d
    |=> (state_q.year == $past(state_q.year)) && (state_q.day == $past(state_q.day))
        && (state_q.hour == $past(state_q.hour)) && (state_q.sec == $past(state_q.sec)))
    else $error("rejected command changed the clock state");

endmodule
